>>> src/csv_pkg.sv
// ----------------------------------------------------------------------------
// csv_pkg
// Shared types and constants for the chunk stream validator.
// ----------------------------------------------------------------------------
package csv_pkg;

  localparam logic [63:0] MAGIC_V11    = 64'h24C4_F02A_AE2E_4FA9;
  localparam logic [63:0] MAGIC_V10    = 64'hCA7F_00D5_DE7E_C7ED;
  localparam logic [63:0] MAGIC_PREV   = 64'hE85B_C563_6CC7_2A05;
  localparam int unsigned OPTIONAL_BIT = 31;
  localparam logic [63:0] STATS_BYTES  = 64'd24;

  localparam logic [31:0] CMD_PAYLOAD = 32'd0;
  localparam logic [31:0] CMD_DISCARD = 32'd1;
  localparam logic [31:0] CMD_BEGIN   = 32'd2;
  localparam logic [31:0] CMD_END     = 32'd3;

  typedef enum logic [1:0] {
    FMT_AUTO = 2'd0,
    FMT_V10  = 2'd1,
    FMT_V11  = 2'd2,
    FMT_NONE = 2'd3
  } format_t;

  typedef enum logic [1:0] {
    VER_NONE = 2'd0,
    VER_10   = 2'd1,
    VER_11   = 2'd2
  } version_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_COPY     = 3'd1,
    ACT_DISCARD  = 3'd2,
    ACT_SKIP     = 3'd3,
    ACT_BEGIN    = 3'd4,
    ACT_END      = 3'd5,
    ACT_FINISHED = 3'd6
  } action_t;

  typedef enum logic [4:0] {
    ST_OK           = 5'd0,
    ST_EMPTY_WARN   = 5'd1,
    ST_MISSING_END  = 5'd2,
    ST_EMPTY_ERR    = 5'd3,
    ST_BEYOND_END   = 5'd4,
    ST_OLD_MAGIC    = 5'd5,
    ST_VER_REJECTED = 5'd6,
    ST_UNKNOWN_MAG  = 5'd7,
    ST_MAG_MISMATCH = 5'd8,
    ST_NO_BEGIN     = 5'd9,
    ST_OLD_BAD_CMD  = 5'd10,
    ST_REP_BEGIN    = 5'd11,
    ST_END_NO_BEGIN = 5'd12,
    ST_END_BAD      = 5'd13,
    ST_STATS_BAD    = 5'd14,
    ST_UNKNOWN_CMD  = 5'd15,
    ST_HALTED       = 5'd16
  } status_t;

  typedef struct packed {
    logic        end_of_input;
    logic [63:0] chunk_magic;
    logic [63:0] chunk_offset;
    logic [63:0] chunk_length;
    logic [31:0] chunk_command;
    logic [63:0] stat_chunks;
    logic [63:0] stat_data;
    logic [63:0] stat_unmap;
  } item_t;

  typedef struct packed {
    action_t     action;
    status_t     status;
    logic [63:0] range_offset;
    logic [63:0] range_length;
  } result_t;

  function automatic logic [63:0] magic_of(version_t v);
    case (v)
      VER_10:  magic_of = MAGIC_V10;
      VER_11:  magic_of = MAGIC_V11;
      default: magic_of = 64'd0;
    endcase
  endfunction

endpackage

>>> src/chunk_stream_validator.sv
// Flow: a header accepted into the input register is checked from there and its result
//   is registered in the result register, which raises out_valid; out_stall holds both.
// Throughput: one header per cycle while out_stall does not hold the result; the running
//   counts update in the same cycle as the checks that read them.
// Reset (rst, synchronous): clears all counts, flags, the locked version, and
//   sets accept_format to auto; both pipeline registers come up empty.
// ----------------------------------------------------------------------------
// chunk_stream_validator
// Checks chunk headers of a stream and gives one result beat per header.
// ----------------------------------------------------------------------------
module chunk_stream_validator import csv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        end_of_input,
  input  logic [63:0] chunk_magic,
  input  logic [63:0] chunk_offset,
  input  logic [63:0] chunk_length,
  input  logic [31:0] chunk_command,
  input  logic [63:0] stat_chunks,
  input  logic [63:0] stat_data,
  input  logic [63:0] stat_unmap,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [4:0]  status,
  output logic [63:0] range_offset,
  output logic [63:0] range_length
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    advance;
  logic    halted;
  result_t check_result;
  result_t result_out;

  assign in_item = '{end_of_input, chunk_magic, chunk_offset, chunk_length,
                     chunk_command, stat_chunks, stat_data, stat_unmap};

  csv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  csv_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (hold_item),
    .result      (check_result),
    .halted      (halted)
  );

  csv_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .result_in  (check_result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_out)
  );

  assign action       = result_out.action;
  assign status       = result_out.status;
  assign range_offset = result_out.range_offset;
  assign range_length = result_out.range_length;

`ifndef SYNTH
  // an error result carries no action and no range
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK && status != ST_EMPTY_WARN |->
      action == ACT_NONE && range_offset == 64'd0 && range_length == 64'd0)
    else $error("error result carries an action or range");

  // input stalls only while the input register is full and cannot drain
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  // once halted, only reset clears it
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");
`endif

endmodule

>>> src/csv_in_stage.sv
// ----------------------------------------------------------------------------
// csv_in_stage
// Input register: captures one header beat and holds it until checked.
// ----------------------------------------------------------------------------
module csv_in_stage import csv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_stall,
  input  logic  advance,
  output logic  hold_valid,
  output item_t hold_item
);

  logic load;

  assign in_stall = hold_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_item <= in_item;
    end
  end

endmodule

>>> src/csv_check.sv
// ----------------------------------------------------------------------------
// csv_check
// Stream state and the per-header checks; state advances with each beat.
// ----------------------------------------------------------------------------
module csv_check import csv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        advance,
  input  item_t       item,
  output result_t     result,
  output logic        halted
);

  logic [1:0]  accept_format;
  logic [63:0] chunk_count;
  logic [63:0] data_count;
  logic [63:0] unmap_count;
  logic        begin_seen;
  logic        end_seen;
  version_t    locked_version;

  logic [63:0] chunk_count_next;
  logic [63:0] data_count_next;
  logic [63:0] unmap_count_next;
  logic        begin_seen_next;
  logic        end_seen_next;
  logic        halted_next;
  version_t    locked_version_next;

  logic [63:0] count_inc;
  logic        first;
  logic        done;
  logic        fmt_v11_ok;
  logic        fmt_v10_ok;
  version_t    ver;

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_format <= 2'd0;
    end else if (cfg_wr_en) begin
      accept_format <= cfg_wr_data;
    end
  end

  assign count_inc  = chunk_count + 64'd1;
  assign first      = (chunk_count == 64'd0);
  assign fmt_v11_ok = (accept_format == FMT_AUTO) || (accept_format == FMT_V11);
  assign fmt_v10_ok = (accept_format == FMT_AUTO) || (accept_format == FMT_V10);

  always_comb begin
    chunk_count_next    = chunk_count;
    data_count_next     = data_count;
    unmap_count_next    = unmap_count;
    begin_seen_next     = begin_seen;
    end_seen_next       = end_seen;
    halted_next         = halted;
    locked_version_next = locked_version;
    result              = '{ACT_NONE, ST_OK, 64'd0, 64'd0};
    ver                 = locked_version;
    done                = 1'b0;

    if (halted) begin
      result.status = ST_HALTED;
    end else if (item.end_of_input) begin
      halted_next = 1'b1;
      if (begin_seen && !end_seen) begin
        result.status = ST_MISSING_END;
      end else if (first) begin
        if (accept_format == FMT_V11) begin
          result.status = ST_EMPTY_ERR;
        end else begin
          result.action = ACT_FINISHED;
          result.status = ST_EMPTY_WARN;
        end
      end else begin
        result.action = ACT_FINISHED;
      end
    end else begin
      chunk_count_next = count_inc;
      if (end_seen) begin
        result.status = ST_BEYOND_END;
        done          = 1'b1;
      end else if (first) begin
        // pick the stream version from the first magic
        if (item.chunk_magic == MAGIC_V11) begin
          if (fmt_v11_ok) begin
            ver = VER_11;
          end else begin
            result.status = ST_VER_REJECTED;
            done          = 1'b1;
          end
        end else if (item.chunk_magic == MAGIC_PREV) begin
          result.status = ST_OLD_MAGIC;
          done          = 1'b1;
        end else if (item.chunk_magic == MAGIC_V10) begin
          if (fmt_v10_ok) begin
            ver = VER_10;
          end else begin
            result.status = ST_VER_REJECTED;
            done          = 1'b1;
          end
        end else begin
          result.status = ST_UNKNOWN_MAG;
          done          = 1'b1;
        end
      end
      locked_version_next = ver;

      if (!done && magic_of(ver) != item.chunk_magic) begin
        result.status = ST_MAG_MISMATCH;
        done          = 1'b1;
      end
      if (!done && first && item.chunk_command != CMD_BEGIN && ver != VER_10) begin
        result.status = ST_NO_BEGIN;
        done          = 1'b1;
      end
      if (!done && ver == VER_10 && item.chunk_command != CMD_PAYLOAD &&
          item.chunk_command != CMD_DISCARD) begin
        result.status = ST_OLD_BAD_CMD;
        done          = 1'b1;
      end

      if (!done) begin
        case (item.chunk_command)
          CMD_PAYLOAD: begin
            data_count_next     = data_count + 64'd1;
            result.action       = ACT_COPY;
            result.range_offset = item.chunk_offset;
            result.range_length = item.chunk_length;
          end
          CMD_DISCARD: begin
            unmap_count_next    = unmap_count + 64'd1;
            result.action       = ACT_DISCARD;
            result.range_offset = item.chunk_offset;
            result.range_length = item.chunk_length;
          end
          CMD_BEGIN: begin
            if (!first) begin
              result.status = ST_REP_BEGIN;
              done          = 1'b1;
            end else begin
              begin_seen_next = 1'b1;
              result.action   = ACT_BEGIN;
            end
          end
          CMD_END: begin
            // the chunk count reported includes the end marker itself
            if (!begin_seen) begin
              result.status = ST_END_NO_BEGIN;
              done          = 1'b1;
            end else if (item.chunk_offset != 64'd0 || item.chunk_length != STATS_BYTES) begin
              result.status = ST_END_BAD;
              done          = 1'b1;
            end else if (item.stat_chunks != count_inc || item.stat_data != data_count ||
                         item.stat_unmap != unmap_count) begin
              result.status = ST_STATS_BAD;
              done          = 1'b1;
            end else begin
              end_seen_next = 1'b1;
              result.action = ACT_END;
            end
          end
          default: begin
            if (item.chunk_command[OPTIONAL_BIT]) begin
              result.action       = ACT_SKIP;
              result.range_length = item.chunk_length;
            end else begin
              result.status = ST_UNKNOWN_CMD;
              done          = 1'b1;
            end
          end
        endcase
      end

      if (done) begin
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count    <= 64'd0;
      data_count     <= 64'd0;
      unmap_count    <= 64'd0;
      begin_seen     <= 1'b0;
      end_seen       <= 1'b0;
      halted         <= 1'b0;
      locked_version <= VER_NONE;
    end else if (advance) begin
      chunk_count    <= chunk_count_next;
      data_count     <= data_count_next;
      unmap_count    <= unmap_count_next;
      begin_seen     <= begin_seen_next;
      end_seen       <= end_seen_next;
      halted         <= halted_next;
      locked_version <= locked_version_next;
    end
  end

endmodule

>>> src/csv_out_stage.sv
// ----------------------------------------------------------------------------
// csv_out_stage
// Result register: holds one result beat while the consumer stalls.
// ----------------------------------------------------------------------------
module csv_out_stage import csv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    hold_valid,
  input  result_t result_in,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result_out
);

  // advance the checked beat when the result slot is free or draining
  assign advance = hold_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out <= result_in;
    end
  end

endmodule

>>> bench/stream_checker.sv
// ----------------------------------------------------------------------------
// stream_checker
// Watches both channels of the chunk stream validator, predicts the result
// beat of every accepted header and compares it field by field with what
// comes out.
// ----------------------------------------------------------------------------
module stream_checker import csv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        end_of_input,
  input  logic [63:0] chunk_magic,
  input  logic [63:0] chunk_offset,
  input  logic [63:0] chunk_length,
  input  logic [31:0] chunk_command,
  input  logic [63:0] stat_chunks,
  input  logic [63:0] stat_data,
  input  logic [63:0] stat_unmap,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  status,
  input  logic [63:0] range_offset,
  input  logic [63:0] range_length,
  output int          fail_count,
  output int          pending,
  output int          compared
);
  timeunit 1ns;
  timeprecision 1ps;

  format_t     accept_fmt;
  version_t    stream_ver;
  logic [63:0] seen_chunks;
  logic [63:0] seen_data;
  logic [63:0] seen_unmap;
  logic        begin_marked;
  logic        end_marked;
  logic        stopped;
  int          n_fail;
  int          n_cmp;
  result_t     pending_verdicts[$];

  function automatic result_t fault(status_t st);
    result_t r;
    stopped = 1'b1;
    r.action       = ACT_NONE;
    r.status       = st;
    r.range_offset = '0;
    r.range_length = '0;
    return r;
  endfunction

  function automatic result_t judge_header(item_t h);
    result_t     r;
    logic        first;
    logic [63:0] locked_magic;
    r.action       = ACT_NONE;
    r.status       = ST_OK;
    r.range_offset = '0;
    r.range_length = '0;
    if (stopped) begin
      r.status = ST_HALTED;
      return r;
    end
    if (h.end_of_input) begin
      if (begin_marked && !end_marked) return fault(ST_MISSING_END);
      stopped = 1'b1;
      if (seen_chunks != 0) begin
        r.action = ACT_FINISHED;
      end else if (accept_fmt == FMT_V11) begin
        r.status = ST_EMPTY_ERR;
      end else begin
        r.action = ACT_FINISHED;
        r.status = ST_EMPTY_WARN;
      end
      return r;
    end

    seen_chunks = seen_chunks + 64'd1;
    if (end_marked) return fault(ST_BEYOND_END);

    // the version is picked again only when the chunk counter wraps to one
    first = (seen_chunks == 64'd1);
    if (first) begin
      if (h.chunk_magic == MAGIC_V11) begin
        if (accept_fmt == FMT_AUTO || accept_fmt == FMT_V11) stream_ver = VER_11;
        else return fault(ST_VER_REJECTED);
      end else if (h.chunk_magic == MAGIC_PREV) begin
        return fault(ST_OLD_MAGIC);
      end else if (h.chunk_magic == MAGIC_V10) begin
        if (accept_fmt == FMT_AUTO || accept_fmt == FMT_V10) stream_ver = VER_10;
        else return fault(ST_VER_REJECTED);
      end else begin
        return fault(ST_UNKNOWN_MAG);
      end
    end

    case (stream_ver)
      VER_10:  locked_magic = MAGIC_V10;
      VER_11:  locked_magic = MAGIC_V11;
      default: locked_magic = '0;
    endcase
    if (h.chunk_magic != locked_magic) return fault(ST_MAG_MISMATCH);
    if (first && h.chunk_command != CMD_BEGIN && stream_ver != VER_10)
      return fault(ST_NO_BEGIN);
    if (stream_ver == VER_10 && h.chunk_command != CMD_PAYLOAD &&
        h.chunk_command != CMD_DISCARD)
      return fault(ST_OLD_BAD_CMD);

    case (h.chunk_command)
      CMD_PAYLOAD: begin
        seen_data      = seen_data + 64'd1;
        r.action       = ACT_COPY;
        r.range_offset = h.chunk_offset;
        r.range_length = h.chunk_length;
      end
      CMD_DISCARD: begin
        seen_unmap     = seen_unmap + 64'd1;
        r.action       = ACT_DISCARD;
        r.range_offset = h.chunk_offset;
        r.range_length = h.chunk_length;
      end
      CMD_BEGIN: begin
        if (!first) return fault(ST_REP_BEGIN);
        begin_marked = 1'b1;
        r.action     = ACT_BEGIN;
      end
      CMD_END: begin
        if (!begin_marked) return fault(ST_END_NO_BEGIN);
        if (h.chunk_offset != 0 || h.chunk_length != STATS_BYTES) return fault(ST_END_BAD);
        // the end marker counts itself
        if (h.stat_chunks != seen_chunks || h.stat_data != seen_data ||
            h.stat_unmap != seen_unmap)
          return fault(ST_STATS_BAD);
        end_marked = 1'b1;
        r.action   = ACT_END;
      end
      default: begin
        if (!h.chunk_command[OPTIONAL_BIT]) return fault(ST_UNKNOWN_CMD);
        r.action       = ACT_SKIP;
        r.range_length = h.chunk_length;
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v)
      flag($sformatf("%s expected %0h, got %0h", what, want_v, got_v));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    item_t   h;
    if (rst) begin
      accept_fmt   = FMT_AUTO;
      stream_ver   = VER_NONE;
      seen_chunks  = '0;
      seen_data    = '0;
      seen_unmap   = '0;
      begin_marked = 1'b0;
      end_marked   = 1'b0;
      stopped      = 1'b0;
      pending_verdicts.delete();
    end else begin
      if (cfg_wr_en) accept_fmt = format_t'(cfg_wr_data);
      // retire the result beat first: it always belongs to an older header
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          flag($sformatf("result beat with nothing pending, action %0d status %0d",
                         action, status));
        end else begin
          want = pending_verdicts.pop_front();
          n_cmp++;
          compare_field("action", 64'(want.action), 64'(action));
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("range_offset", want.range_offset, range_offset);
          compare_field("range_length", want.range_length, range_length);
        end
      end
      if (in_valid && !in_stall) begin
        h.end_of_input  = end_of_input;
        h.chunk_magic   = chunk_magic;
        h.chunk_offset  = chunk_offset;
        h.chunk_length  = chunk_length;
        h.chunk_command = chunk_command;
        h.stat_chunks   = stat_chunks;
        h.stat_data     = stat_data;
        h.stat_unmap    = stat_unmap;
        pending_verdicts.push_back(judge_header(h));
      end
    end
    fail_count <= n_fail;
    pending    <= pending_verdicts.size();
    compared   <= n_cmp;
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives chunk headers into the chunk stream validator: one long stream per
// run, of a version picked at random, with a short directed opening, random
// data/unmap/optional chunks, and a random closing case (finish, missing end,
// bad marker, mismatch). Runs picking a failing first header are mixed in.
// Idling and stalls change per phase; the checker gives the failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csv_pkg::*;

  localparam int          HEADERS     = 1900;
  localparam int          PHASE_LEN   = 240;
  localparam int          QUIET_LIMIT = 2000;
  localparam logic [31:0] OPT_FLAG    = 32'd1 << OPTIONAL_BIT;

  typedef enum int {
    OPEN_V11, OPEN_V10, OPEN_EMPTY, OPEN_UNKNOWN_MAGIC, OPEN_OLD_MAGIC,
    OPEN_REJECT, OPEN_NO_BEGIN
  } opening_e;

  typedef enum int {
    TERM_NONE, TERM_FINISH, TERM_BEYOND, TERM_MISSING, TERM_MAGIC, TERM_REBEGIN,
    TERM_SHAPE, TERM_STATS, TERM_UNKNOWN, TERM_OLD_CMD
  } closing_e;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_wr_data   = FMT_AUTO;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        end_of_input  = 1'b0;
  logic [63:0] chunk_magic   = '0;
  logic [63:0] chunk_offset  = '0;
  logic [63:0] chunk_length  = '0;
  logic [31:0] chunk_command = '0;
  logic [63:0] stat_chunks   = '0;
  logic [63:0] stat_data     = '0;
  logic [63:0] stat_unmap    = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [2:0]  action;
  logic [4:0]  status;
  logic [63:0] range_offset;
  logic [63:0] range_length;
  int          fail_count;
  int          pending;
  int          compared;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          sent      = 0;
  int          phase     = 0;
  int          n_writes  = 0;
  int          quiet     = 0;
  logic [63:0] stream_magic = MAGIC_V11;
  logic [63:0] total_count  = '0;
  logic [63:0] n_data       = '0;
  logic [63:0] n_unmap      = '0;
  opening_e    opening      = OPEN_V11;
  closing_e    closing      = TERM_NONE;

  always #10 clk = ~clk;

  chunk_stream_validator u_top (.*);

  stream_checker u_check (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // end the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(255));
      3:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic item_t make_header(logic [63:0] magic, logic [31:0] cmd,
                                        logic [63:0] off, logic [63:0] len);
    item_t h;
    h.end_of_input  = 1'b0;
    h.chunk_magic   = magic;
    h.chunk_offset  = off;
    h.chunk_length  = len;
    h.chunk_command = cmd;
    h.stat_chunks   = pick64();
    h.stat_data     = pick64();
    h.stat_unmap    = pick64();
    return h;
  endfunction

  function automatic item_t noise_header();
    item_t       h;
    logic [63:0] magic;
    case ($urandom_range(3))
      0:       magic = MAGIC_V11;
      1:       magic = MAGIC_V10;
      2:       magic = MAGIC_PREV;
      default: magic = {$urandom, $urandom};
    endcase
    h = make_header(magic, $urandom, pick64(), pick64());
    h.end_of_input = ($urandom_range(3) == 0);
    return h;
  endfunction

  task automatic write_format(input format_t fmt);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  // hold the sender until every result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_beat(input item_t h);
    if (sent != 0 && sent % PHASE_LEN == 0) begin
      settle();
      phase++;
      write_format(format_t'(2'(phase)));
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    end_of_input  <= h.end_of_input;
    chunk_magic   <= h.chunk_magic;
    chunk_offset  <= h.chunk_offset;
    chunk_length  <= h.chunk_length;
    chunk_command <= h.chunk_command;
    stat_chunks   <= h.stat_chunks;
    stat_data     <= h.stat_data;
    stat_unmap    <= h.stat_unmap;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // send a header of the running stream and keep the end-marker statistics
  task automatic push_header(input logic [31:0] cmd, input logic [63:0] off,
                             input logic [63:0] len);
    item_t h;
    total_count = total_count + 64'd1;
    if (cmd == CMD_PAYLOAD) n_data = n_data + 64'd1;
    if (cmd == CMD_DISCARD) n_unmap = n_unmap + 64'd1;
    h = make_header(stream_magic, cmd, off, len);
    if (cmd == CMD_END) begin
      h.stat_chunks = total_count;
      h.stat_data   = n_data;
      h.stat_unmap  = n_unmap;
    end
    put_beat(h);
  endtask

  task automatic send_body_item();
    int          pick;
    logic [31:0] cmd;
    pick = $urandom_range(9);
    // the old version carries only data and unmap
    if (stream_magic == MAGIC_V10 && pick >= 7) pick = pick - 7;
    if (pick <= 3) begin
      push_header(CMD_PAYLOAD, pick64(), pick64());
    end else if (pick <= 6) begin
      push_header(CMD_DISCARD, pick64(), pick64());
    end else begin
      cmd = $urandom;
      if ($urandom_range(1)) cmd[30:0] = 31'($urandom_range(3));
      push_header(cmd | OPT_FLAG, pick64(), pick64());
    end
  endtask

  initial begin : stimulus
    item_t       h;
    int          pick;
    format_t     fmt;
    logic [63:0] off;
    logic [63:0] len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_format(FMT_NONE);

    pick = $urandom_range(11);
    if (pick <= 6) opening = OPEN_V11;
    else if (pick <= 9) opening = OPEN_V10;
    else opening = opening_e'($urandom_range(OPEN_NO_BEGIN, OPEN_EMPTY));

    case (opening)
      OPEN_V11, OPEN_NO_BEGIN: begin
        stream_magic = MAGIC_V11;
        fmt = $urandom_range(1) ? FMT_AUTO : FMT_V11;
      end
      OPEN_V10: begin
        stream_magic = MAGIC_V10;
        fmt = $urandom_range(1) ? FMT_AUTO : FMT_V10;
      end
      OPEN_REJECT: begin
        if ($urandom_range(1)) begin
          stream_magic = MAGIC_V11;
          fmt = $urandom_range(1) ? FMT_V10 : FMT_NONE;
        end else begin
          stream_magic = MAGIC_V10;
          fmt = $urandom_range(1) ? FMT_V11 : FMT_NONE;
        end
      end
      OPEN_OLD_MAGIC: begin
        stream_magic = MAGIC_PREV;
        fmt = format_t'($urandom_range(3));
      end
      default: begin
        stream_magic = {$urandom, $urandom};
        fmt = format_t'($urandom_range(3));
      end
    endcase
    write_format(fmt);

    case (opening)
      OPEN_V11, OPEN_V10: begin
        // directed opening: field extremes of data and unmap chunks, plus begin and optional chunks for v1.1
        if (opening == OPEN_V11) push_header(CMD_BEGIN, '1, '1);
        else push_header(CMD_PAYLOAD, '1, '1);
        push_header(CMD_PAYLOAD, '0, '0);
        push_header(CMD_PAYLOAD, '1, '1);
        push_header(CMD_DISCARD, '0, '1);
        push_header(CMD_DISCARD, '1, '0);
        push_header(CMD_PAYLOAD, {16{4'h5}}, {16{4'hA}});
        push_header(CMD_DISCARD, {16{4'hA}}, {16{4'h5}});
        if (opening == OPEN_V11) begin
          push_header(OPT_FLAG | CMD_PAYLOAD, '1, '1);
          push_header(OPT_FLAG | 32'h7FFF_FFFF, '0, '0);
          push_header(OPT_FLAG | CMD_BEGIN, '0, STATS_BYTES);
          push_header(OPT_FLAG | CMD_END, '0, STATS_BYTES);
        end

        while (sent < HEADERS - 60) send_body_item();

        if (opening == OPEN_V11) begin
          closing = closing_e'($urandom_range(TERM_UNKNOWN, TERM_FINISH));
        end else begin
          case ($urandom_range(2))
            0:       closing = TERM_FINISH;
            1:       closing = TERM_MAGIC;
            default: closing = TERM_OLD_CMD;
          endcase
        end
        if (opening == OPEN_V11 && (closing == TERM_FINISH || closing == TERM_BEYOND))
          push_header(CMD_END, '0, STATS_BYTES);

        case (closing)
          TERM_FINISH, TERM_MISSING: begin
            h = noise_header();
            h.end_of_input = 1'b1;
            put_beat(h);
          end
          TERM_BEYOND: send_body_item();
          TERM_MAGIC: begin
            if ($urandom_range(1))
              h = make_header(stream_magic ^ ({$urandom, $urandom} | 64'd1), CMD_PAYLOAD,
                              pick64(), pick64());
            else
              h = make_header(MAGIC_PREV, CMD_DISCARD, pick64(), pick64());
            put_beat(h);
          end
          TERM_REBEGIN: push_header(CMD_BEGIN, pick64(), pick64());
          TERM_SHAPE: begin
            if ($urandom_range(1)) begin
              off = pick64();
              if (off == 0) off = 64'd1;
              len = STATS_BYTES;
            end else begin
              off = '0;
              len = pick64();
              if (len == STATS_BYTES) len = len + 64'd1;
            end
            push_header(CMD_END, off, len);
          end
          TERM_STATS: begin
            h = make_header(stream_magic, CMD_END, '0, STATS_BYTES);
            h.stat_chunks = total_count + 64'd1;
            h.stat_data   = n_data;
            h.stat_unmap  = n_unmap;
            case ($urandom_range(2))
              0:       h.stat_chunks ^= {$urandom, $urandom} | 64'd1;
              1:       h.stat_data   ^= {$urandom, $urandom} | 64'd1;
              default: h.stat_unmap  ^= {$urandom, $urandom} | 64'd1;
            endcase
            put_beat(h);
          end
          TERM_UNKNOWN:
            push_header($urandom_range(32'h7FFF_FFFF, CMD_END + 1), pick64(), pick64());
          default: begin
            case ($urandom_range(3))
              0:       push_header(CMD_BEGIN, pick64(), pick64());
              1:       push_header(CMD_END, '0, STATS_BYTES);
              2:       push_header(OPT_FLAG | $urandom, pick64(), pick64());
              default: push_header($urandom_range(32'h7FFF_FFFF, CMD_END + 1), pick64(),
                                   pick64());
            endcase
          end
        endcase
      end
      OPEN_EMPTY: begin
        h = noise_header();
        h.end_of_input = 1'b1;
        put_beat(h);
      end
      OPEN_NO_BEGIN: begin
        case ($urandom_range(3))
          0:       push_header(CMD_PAYLOAD, pick64(), pick64());
          1:       push_header(CMD_DISCARD, pick64(), pick64());
          2:       push_header(CMD_END, '0, STATS_BYTES);
          default: push_header(OPT_FLAG | $urandom, pick64(), pick64());
        endcase
      end
      default: push_header($urandom_range(1) ? CMD_BEGIN : 32'($urandom), pick64(),
                           pick64());
    endcase

    // everything past the closing header answers as halted
    while (sent < HEADERS) put_beat(noise_header());

    settle();
    repeat (5) @(posedge clk);
    $display("summary: opening %s, closing %s, %0d format writes over %0d phases",
             opening.name(), closing.name(), n_writes, phase + 1);
    $display("summary: %0d headers sent, %0d result beats compared, %0d mismatches",
             sent, compared, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/csv_pkg.sv
src/csv_in_stage.sv
src/csv_check.sv
src/csv_out_stage.sv
src/chunk_stream_validator.sv
bench/stream_checker.sv
bench/testbench.sv
